>>> design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and phase tables shared by the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned PhaseW   = 5;
  localparam int unsigned TickW    = 16;
  localparam logic [TickW-1:0] PhaseTicksRst = 16'd10;

  localparam logic [0:0] RegPhaseTicks = 1'b0;

  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_RECV     = 3'd4,
    CMD_SEND_ACK = 3'd5,
    CMD_RECV_ACK = 3'd6
  } cmd_e;

  // Position inside a three-phase bit slot.
  typedef enum logic [1:0] {
    SLOT_DATA = 2'd0,
    SLOT_HIGH = 2'd1,
    SLOT_LOW  = 2'd2
  } slot_e;

  typedef struct packed {
    logic [2:0]          op;
    logic [DataBits-1:0] tx_byte;
    logic                ack_to_send;
    logic                sda_in;
  } in_t;

  typedef struct packed {
    logic                scl_out;
    logic                sda_out;
    logic                busy_res;
    logic                done_res;
    logic [DataBits-1:0] rx_byte;
    logic                rx_ack;
  } out_t;

  typedef struct packed {
    logic set_scl;
    logic scl_val;
    logic set_sda;
    logic sda_val;
    logic shift_tx;
    logic sample_rx;
    logic sample_ack;
  } act_t;

  function automatic logic [PhaseW-1:0] phase_count(cmd_e cmd);
    logic [PhaseW-1:0] n;
    case (cmd)
      CMD_START:    n = PhaseW'(4);
      CMD_STOP:     n = PhaseW'(3);
      CMD_SEND:     n = PhaseW'(3 * DataBits);
      CMD_RECV:     n = PhaseW'(3 * DataBits + 1);
      CMD_SEND_ACK: n = PhaseW'(3);
      CMD_RECV_ACK: n = PhaseW'(4);
      default:      n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> design/i2cms_action.sv
// ----------------------------------------------------------------------------
// i2cms_action
// Decodes the pin action of the current phase of the active command.
// ----------------------------------------------------------------------------
module i2cms_action (
  input  i2cms_pkg::cmd_e              cmd_i,
  input  logic [i2cms_pkg::PhaseW-1:0] phase_i,
  input  i2cms_pkg::slot_e             slot_i,
  input  logic                         tx_msb_i,
  output i2cms_pkg::act_t              act_o
);
  import i2cms_pkg::*;

  always_comb begin
    act_o = '0;
    case (cmd_i)
      CMD_START: begin
        case (phase_i)
          PhaseW'(0): begin act_o.set_sda = 1'b1; act_o.sda_val = 1'b1; end
          PhaseW'(1): begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
          PhaseW'(2): begin act_o.set_sda = 1'b1; act_o.sda_val = 1'b0; end
          default:    begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b0; end
        endcase
      end
      CMD_STOP: begin
        case (phase_i)
          PhaseW'(0): begin act_o.set_sda = 1'b1; act_o.sda_val = 1'b0; end
          PhaseW'(1): begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
          default:    begin act_o.set_sda = 1'b1; act_o.sda_val = 1'b1; end
        endcase
      end
      CMD_SEND: begin
        case (slot_i)
          SLOT_DATA: begin act_o.set_sda = 1'b1; act_o.sda_val = tx_msb_i; end
          SLOT_HIGH: begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
          default: begin
            act_o.set_scl  = 1'b1;
            act_o.scl_val  = 1'b0;
            act_o.shift_tx = 1'b1;
          end
        endcase
      end
      CMD_RECV: begin
        if (phase_i == '0) begin
          act_o.set_sda = 1'b1;
          act_o.sda_val = 1'b1;
        end else begin
          case (slot_i)
            SLOT_DATA: begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
            SLOT_HIGH: act_o.sample_rx = 1'b1;
            default:   begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b0; end
          endcase
        end
      end
      CMD_SEND_ACK: begin
        case (phase_i)
          PhaseW'(0): begin act_o.set_sda = 1'b1; act_o.sda_val = tx_msb_i; end
          PhaseW'(1): begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
          default:    begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b0; end
        endcase
      end
      CMD_RECV_ACK: begin
        case (phase_i)
          PhaseW'(0): begin act_o.set_sda = 1'b1; act_o.sda_val = 1'b1; end
          PhaseW'(1): begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b1; end
          PhaseW'(2): act_o.sample_ack = 1'b1;
          default:    begin act_o.set_scl = 1'b1; act_o.scl_val = 1'b0; end
        endcase
      end
      default: act_o = '0;
    endcase
  end

endmodule

>>> design/i2c_master_bit_sequencer.sv
// An accepted tick beat's result beat is registered and is valid in the next cycle.
// Throughput: one tick beat per cycle; the only stall is a held result register.
// The per-tick pin and phase update is one pass of decode and a 16-bit compare.
// Reset: asynchronous, active low; idle, SCL and SDA released, phase_ticks = 10.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Tick-driven I2C master pin sequencer with an APB register for phase length.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  i2cms_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output i2cms_pkg::out_t  out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cms_pkg::*;

  logic [TickW-1:0]    phase_ticks_q;
  cmd_e                cmd_q, cmd_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  slot_e               slot_q, slot_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic [DataBits-1:0] tx_q, tx_d;
  logic [DataBits-1:0] rx_q, rx_d;
  logic                ack_q, ack_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                out_valid_q;
  out_t                out_q, out_d;

  cmd_e                cur_cmd;
  logic [PhaseW-1:0]   cur_phase;
  slot_e               cur_slot;
  logic [TickW-1:0]    cur_tick;
  logic [DataBits-1:0] cur_tx;
  logic [TickW-1:0]    limit;
  logic                launch;
  logic                done;
  logic                accept;
  act_t                act;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPhaseTicks) ? {16'b0, phase_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksRst;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegPhaseTicks) begin
      phase_ticks_q <= pwdata[TickW-1:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    launch = (cmd_q == CMD_IDLE) && (in_data_i.op inside {[3'd1:3'd6]});
    if (launch) begin
      cur_cmd   = cmd_e'(in_data_i.op);
      cur_phase = '0;
      cur_slot  = SLOT_DATA;
      cur_tick  = '0;
      case (cmd_e'(in_data_i.op))
        CMD_SEND:     cur_tx = in_data_i.tx_byte;
        CMD_SEND_ACK: cur_tx = {in_data_i.ack_to_send, {(DataBits-1){1'b0}}};
        default:      cur_tx = tx_q;
      endcase
    end else begin
      cur_cmd   = cmd_q;
      cur_phase = phase_q;
      cur_slot  = slot_q;
      cur_tick  = tick_q;
      cur_tx    = tx_q;
    end
  end

  i2cms_action u_action (
    .cmd_i    (cur_cmd),
    .phase_i  (cur_phase),
    .slot_i   (cur_slot),
    .tx_msb_i (cur_tx[DataBits-1]),
    .act_o    (act)
  );

  assign limit = (phase_ticks_q == '0) ? TickW'(1) : phase_ticks_q;

  always_comb begin
    cmd_d   = cur_cmd;
    phase_d = cur_phase;
    slot_d  = cur_slot;
    tick_d  = cur_tick;
    tx_d    = cur_tx;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;
    if (cur_cmd != CMD_IDLE) begin
      if (cur_tick == '0) begin
        if (act.set_scl)    scl_d = act.scl_val;
        if (act.set_sda)    sda_d = act.sda_val;
        if (act.shift_tx)   tx_d  = {cur_tx[DataBits-2:0], 1'b0};
        if (act.sample_rx)  rx_d  = {rx_q[DataBits-2:0], in_data_i.sda_in};
        if (act.sample_ack) ack_d = in_data_i.sda_in;
      end
      tick_d = cur_tick + TickW'(1);
      if (tick_d >= limit) begin
        tick_d  = '0;
        phase_d = cur_phase + PhaseW'(1);
        if (!(cur_cmd == CMD_RECV && cur_phase == '0)) begin
          case (cur_slot)
            SLOT_DATA: slot_d = SLOT_HIGH;
            SLOT_HIGH: slot_d = SLOT_LOW;
            default:   slot_d = SLOT_DATA;
          endcase
        end
        if (phase_d >= phase_count(cur_cmd)) begin
          cmd_d   = CMD_IDLE;
          phase_d = '0;
          slot_d  = SLOT_DATA;
          done    = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_d.scl_out  = scl_d;
    out_d.sda_out  = sda_d;
    out_d.busy_res = (cmd_d != CMD_IDLE);
    out_d.done_res = done;
    out_d.rx_byte  = rx_d;
    out_d.rx_ack   = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_IDLE;
      phase_q     <= '0;
      slot_q      <= SLOT_DATA;
      tick_q      <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cmd_q   <= cmd_d;
        phase_q <= phase_d;
        slot_q  <= slot_d;
        tick_q  <= tick_d;
        tx_q    <= tx_d;
        rx_q    <= rx_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Idle sequencer keeps its phase and tick counters cleared.
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_IDLE |-> phase_q == '0 && tick_q == '0 && slot_q == SLOT_DATA)
    else $error("idle sequencer with live phase state");

  // Phase index stays inside the active command's phase list.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q != CMD_IDLE |-> phase_q < phase_count(cmd_q))
    else $error("phase index past end of command");

  // A completion beat never reports busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done and busy in one result beat");

  // An accepted tick always yields a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat produced no result");

endmodule

>>> dv/tb_i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer
// Self-checking bench for the tick-driven I2C master pin sequencer. A
// directed table walks every command, the byte and ack extremes, busy
// commands, the undefined op and the phase length extremes (0, 1, 65535).
// Random command sequences with noise then run under several phase lengths.
// Each result beat is checked field by field against an in-bench pin model, or for typed rows against table pins.
// Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer;
  import i2cms_pkg::*;

  localparam logic [2:0] OpUndef   = 3'd7;
  localparam logic [2:0] TicksAddr = {RegPhaseTicks, 2'b00};
  localparam out_t       RstPins   = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

  typedef struct packed {
    logic                wr;
    logic [TickW-1:0]    ticks;
    in_t                 beat;
    logic [5:0]          reps;
    logic                typed;
    out_t                pins;
  } dir_row_t;

  // wr, ticks, beat {op, tx_byte, ack, sda}, reps, typed, pins
  localparam dir_row_t DirRows [20] = '{
    '{1'b0, 16'd0,     '{CMD_IDLE,     8'h00, 1'b0, 1'b0}, 6'd1,  1'b1, RstPins},
    '{1'b0, 16'd0,     '{OpUndef,      8'hFF, 1'b1, 1'b1}, 6'd1,  1'b1, RstPins},
    '{1'b1, 16'd0,     '0,                                 6'd0,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_START,    8'h00, 1'b0, 1'b0}, 6'd1,  1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{1'b0, 16'd0,     '{CMD_SEND,     8'hA5, 1'b1, 1'b0}, 6'd3,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_SEND,     8'hFF, 1'b0, 1'b1}, 6'd24, 1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_SEND,     8'h00, 1'b1, 1'b0}, 6'd24, 1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_RECV,     8'h00, 1'b0, 1'b1}, 6'd25, 1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_RECV,     8'hFF, 1'b1, 1'b0}, 6'd25, 1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_RECV_ACK, 8'h00, 1'b0, 1'b1}, 6'd4,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_RECV_ACK, 8'h00, 1'b1, 1'b0}, 6'd4,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_SEND_ACK, 8'h00, 1'b1, 1'b0}, 6'd3,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_SEND_ACK, 8'hFF, 1'b0, 1'b1}, 6'd3,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_STOP,     8'h00, 1'b0, 1'b0}, 6'd3,  1'b0, '0},
    '{1'b1, 16'hFFFF,  '0,                                 6'd0,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_START,    8'h00, 1'b0, 1'b0}, 6'd5,  1'b0, '0},
    '{1'b1, 16'd1,     '0,                                 6'd0,  1'b0, '0},
    '{1'b0, 16'd0,     '{OpUndef,      8'h3C, 1'b1, 1'b1}, 6'd4,  1'b0, '0},
    '{1'b1, 16'd2,     '0,                                 6'd0,  1'b0, '0},
    '{1'b0, 16'd0,     '{CMD_SEND,     8'h5A, 1'b0, 1'b1}, 6'd50, 1'b0, '0}
  };

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // pin model state
  cmd_e               pm_cmd   = CMD_IDLE;
  logic [PhaseW-1:0]  pm_phase = '0;
  logic [TickW-1:0]   pm_tick  = '0;
  logic [TickW-1:0]   pm_ticks = PhaseTicksRst;
  logic [7:0]         pm_tx    = '0;
  logic [7:0]         pm_rx    = '0;
  logic               pm_ack   = 1'b0;
  logic               pm_scl   = 1'b1;
  logic               pm_sda   = 1'b1;

  out_t pins_q[$];
  logic beat_typed = 1'b0;
  out_t beat_pins  = '0;
  bit   idle_en    = 1'b1;
  int   mismatches = 0;
  int   stall_cnt  = 0;

  i2c_master_bit_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned phase_len(cmd_e c);
    case (c)
      CMD_START:    return 4;
      CMD_STOP:     return 3;
      CMD_SEND:     return 3 * DataBits;
      CMD_RECV:     return 3 * DataBits + 1;
      CMD_SEND_ACK: return 3;
      CMD_RECV_ACK: return 4;
      default:      return 0;
    endcase
  endfunction

  // advance the pin model by one tick and return the expected pins
  function automatic out_t tick_pins(in_t it);
    logic        fin;
    int unsigned lim;
    int unsigned slot;
    fin = 1'b0;
    if (pm_cmd == CMD_IDLE && it.op >= CMD_START && it.op <= CMD_RECV_ACK) begin
      pm_cmd   = cmd_e'(it.op);
      pm_phase = '0;
      pm_tick  = '0;
      if (pm_cmd == CMD_SEND) begin
        pm_tx = it.tx_byte;
      end else if (pm_cmd == CMD_SEND_ACK) begin
        pm_tx = {it.ack_to_send, 7'b0};
      end
    end
    if (pm_cmd != CMD_IDLE) begin
      if (pm_tick == '0) begin
        case (pm_cmd)
          CMD_START: begin
            case (pm_phase)
              0:       pm_sda = 1'b1;
              1:       pm_scl = 1'b1;
              2:       pm_sda = 1'b0;
              default: pm_scl = 1'b0;
            endcase
          end
          CMD_STOP: begin
            case (pm_phase)
              0:       pm_sda = 1'b0;
              1:       pm_scl = 1'b1;
              default: pm_sda = 1'b1;
            endcase
          end
          CMD_SEND: begin
            slot = pm_phase % 3;
            if (slot == SLOT_DATA) begin
              pm_sda = pm_tx[DataBits-1];
            end else if (slot == SLOT_HIGH) begin
              pm_scl = 1'b1;
            end else begin
              pm_scl = 1'b0;
              pm_tx  = pm_tx << 1;
            end
          end
          CMD_RECV: begin
            if (pm_phase == 0) begin
              pm_sda = 1'b1;
            end else begin
              slot = (pm_phase - 1) % 3;
              if (slot == 0) begin
                pm_scl = 1'b1;
              end else if (slot == 1) begin
                pm_rx = {pm_rx[6:0], it.sda_in};
              end else begin
                pm_scl = 1'b0;
              end
            end
          end
          CMD_SEND_ACK: begin
            case (pm_phase)
              0:       pm_sda = pm_tx[DataBits-1];
              1:       pm_scl = 1'b1;
              default: pm_scl = 1'b0;
            endcase
          end
          default: begin
            case (pm_phase)
              0:       pm_sda = 1'b1;
              1:       pm_scl = 1'b1;
              2:       pm_ack = it.sda_in;
              default: pm_scl = 1'b0;
            endcase
          end
        endcase
      end
      pm_tick = pm_tick + 1'b1;
      lim = (pm_ticks == '0) ? 1 : pm_ticks;
      if (pm_tick >= lim) begin
        pm_tick  = '0;
        pm_phase = pm_phase + 1'b1;
        if (pm_phase >= phase_len(pm_cmd)) begin
          pm_cmd   = CMD_IDLE;
          pm_phase = '0;
          fin      = 1'b1;
        end
      end
    end
    return '{pm_scl, pm_sda, pm_cmd != CMD_IDLE, fin, pm_rx, pm_ack};
  endfunction

  // result side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt   <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt   <= stall_cnt - 1;
      out_ready_i <= (stall_cnt == 1);
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      stall_cnt   <= $urandom_range(1, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : scoreboard
    out_t want;
    out_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pins_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing expected");
        end else begin
          want = pins_q.pop_front();
          if (out_data_o.scl_out !== want.scl_out || out_data_o.sda_out !== want.sda_out ||
              out_data_o.busy_res !== want.busy_res ||
              out_data_o.done_res !== want.done_res ||
              out_data_o.rx_byte !== want.rx_byte || out_data_o.rx_ack !== want.rx_ack) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("pin mismatch: exp scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                       want.scl_out, want.sda_out, want.busy_res, want.done_res,
                       want.rx_byte, want.rx_ack);
              $display("              got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                       out_data_o.scl_out, out_data_o.sda_out, out_data_o.busy_res,
                       out_data_o.done_res, out_data_o.rx_byte, out_data_o.rx_ack);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = tick_pins(in_data_i);
        pins_q.push_back(beat_typed ? beat_pins : pred);
      end
    end
  end

  task automatic push_beat(input in_t it, input logic typed, input out_t pins);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    beat_typed <= typed;
    beat_pins  <= pins;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pins_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_beat(input logic wr, input logic [TickW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TicksAddr;
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      pm_ticks = val;
    end else if (prdata !== {16'h0, pm_ticks}) begin
      mismatches++;
      if (mismatches <= 10) $display("phase_ticks read: exp %h got %h", pm_ticks, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_phase_ticks(input logic [TickW-1:0] val);
    settle();
    apb_beat(1'b0, '0);
    apb_beat(1'b1, val);
    apb_beat(1'b0, '0);
  endtask

  task automatic run_traffic(input int n);
    int   sent;
    int   fill;
    int   k;
    in_t  it;
    cmd_e c;
    sent = 0;
    while (sent < n) begin
      it.tx_byte     = 8'($urandom_range(0, 255));
      it.ack_to_send = 1'($urandom_range(0, 1));
      it.sda_in      = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8) begin
        c     = cmd_e'($urandom_range(CMD_START, CMD_RECV_ACK));
        it.op = c;
        push_beat(it, 1'b0, '0);
        sent++;
        fill = phase_len(c) * ((pm_ticks == '0) ? 1 : pm_ticks) - 1;
        if ($urandom_range(0, 7) == 0) fill = $urandom_range(0, fill);
        fill += $urandom_range(0, 2);
        for (k = 0; k < fill && sent < n; k++) begin
          it.op = CMD_IDLE;
          if ($urandom_range(0, 5) == 0) it.op = 3'($urandom_range(0, 7));
          it.tx_byte     = 8'($urandom_range(0, 255));
          it.ack_to_send = 1'($urandom_range(0, 1));
          it.sda_in      = 1'($urandom_range(0, 1));
          push_beat(it, 1'b0, '0);
          sent++;
        end
      end else begin
        it.op = 3'($urandom_range(0, 7));
        push_beat(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("i2c_master_bit_sequencer verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [TickW-1:0] plan_ticks [7];
    int               plan_beats [7];
    int               ph;
    int               r;
    plan_ticks = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd6, 16'd3, 16'd1};
    plan_beats = '{70, 70, 70, 30, 90, 90, 100};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < 20; r++) begin
      if (DirRows[r].wr) begin
        set_phase_ticks(DirRows[r].ticks);
      end else begin
        repeat (DirRows[r].reps) push_beat(DirRows[r].beat, DirRows[r].typed, DirRows[r].pins);
      end
    end

    for (ph = 0; ph < 7; ph++) begin
      if (ph == 4) plan_ticks[ph] = TickW'($urandom_range(4, 12));
      set_phase_ticks(plan_ticks[ph]);
      idle_en = (ph == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
      run_traffic(plan_beats[ph]);
    end

    settle();
    if (mismatches == 0 && pins_q.size() == 0) begin
      $display("i2c_master_bit_sequencer verification clean");
    end else begin
      $display("i2c_master_bit_sequencer verification failed");
    end
    $finish;
  end

endmodule
